[rtl/stmf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stmf_pkg
// Shared sizes, types and state codes for the trimmed-mean filter.
// ----------------------------------------------------------------------------
package stmf_pkg;

    // Window depth and the widths that follow from it
    localparam int WINDOW = 8;
    localparam int DATA_W = 16;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int SUM_W  = DATA_W + $clog2(WINDOW);
    localparam int DCNT_W = $clog2(SUM_W + 1);

    // Smallest fill level that gives a trimmed mean
    localparam int MIN_HELD = 3;

    // Control flow of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TRIM,
        ST_DIV,
        ST_DONE
    } stmf_state_t;

    // Status handed back by the serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } stmf_div_stat_t;

endpackage : stmf_pkg
`default_nettype wire

[rtl/stmf_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stmf_cell
// One window cell: holds a sample and takes its neighbour's word when enabled.
// ----------------------------------------------------------------------------
module stmf_cell
    import stmf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [DATA_W-1:0] din,
    output logic      [DATA_W-1:0] q
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // hold unless the chain advances
    always_comb
    begin
        data_next = en ? din : data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule : stmf_cell
`default_nettype wire

[rtl/stmf_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stmf_div
// Restoring divider, one quotient bit per cycle, SUM_W quotient bits per divide.
// ----------------------------------------------------------------------------
module stmf_div
    import stmf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SUM_W-1:0]  dividend,
    input  wire logic [CNT_W-1:0]  divisor,
    output stmf_div_stat_t         stat,
    output logic      [DATA_W-1:0] quotient
);

    logic [SUM_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  quo_next;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W:0]    rem_next;
    logic [CNT_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  dvs_next;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DCNT_W-1:0] cnt_next;
    logic              done_reg;
    logic              done_next;

    logic [CNT_W:0]    rem_sh;
    logic              ge;

    // trial subtract of the shifted remainder
    always_comb
    begin
        rem_sh = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
        ge     = (rem_sh >= {1'b0, dvs_reg});
    end

    // load on start, otherwise advance one bit while running
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = DCNT_W'(SUM_W);
        end
        else if (cnt_reg != '0)
        begin
            quo_next  = {quo_reg[SUM_W-2:0], ge};
            rem_next  = ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            cnt_next  = cnt_reg - DCNT_W'(1);
            done_next = (cnt_reg == DCNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg[DATA_W-1:0];

endmodule : stmf_div
`default_nettype wire

[rtl/sliding_trimmed_mean_filter_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_trimmed_mean_filter_core
// Moving average over the last WINDOW samples with one maximum and one
// minimum left out; raw sample passed while fewer than three are held or the mean is zero.
// ----------------------------------------------------------------------------
// From accept to result: one pass round the cell chain in ST_SCAN, the trim in
// ST_TRIM, one quotient bit per cycle in the divider, ST_DIV to see it finish
// and ST_DONE to load the output; while fewer than three samples are held the
// word goes from ST_IDLE straight to ST_DONE. A new word is taken only in
// ST_IDLE, once the last one is through; the next word is taken while a result
// still waits on the output, and ST_DONE waits while an older one is untaken.
// Reset clears the fill count and all handshakes; the window cells are not
// cleared.
// ----------------------------------------------------------------------------
module sliding_trimmed_mean_filter_core
    import stmf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [15:0] filtered
    output logic      [0:0]  m_tuser    // [0] passthrough
);

    stmf_state_t state_reg;
    stmf_state_t state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [DATA_W-1:0] hi_reg;
    logic [DATA_W-1:0] hi_next;
    logic [DATA_W-1:0] lo_reg;
    logic [DATA_W-1:0] lo_next;
    logic [DATA_W-1:0] sample_reg;
    logic [DATA_W-1:0] sample_next;
    logic              warm_reg;
    logic              warm_next;
    logic              ovalid_reg;
    logic              ovalid_next;
    logic [DATA_W-1:0] ofilt_reg;
    logic [DATA_W-1:0] ofilt_next;
    logic              opass_reg;
    logic              opass_next;

    logic              accept;
    logic              chain_en;
    logic              in_scan;
    logic              div_start;
    logic              out_load;
    logic [CNT_W-1:0]  count_inc;
    logic [CNT_W-1:0]  skip;
    logic              take;
    logic              first;
    logic              scan_last;
    logic [DATA_W-1:0] tap;
    logic [SUM_W-1:0]  trimmed;
    logic [CNT_W-1:0]  divisor;
    logic              mean_zero;

    logic [DATA_W-1:0] cell_q [WINDOW];

    stmf_div_stat_t    div_stat;
    logic [DATA_W-1:0] quotient;

    // Cell chain: shift in the new word on accept, rotate during the scan
    assign tap = cell_q[WINDOW-1];

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        logic [DATA_W-1:0] din;
        if (i == 0)
        begin : g_head
            assign din = in_scan ? tap : s_tdata;
        end
        else
        begin : g_body
            assign din = cell_q[i-1];
        end
        stmf_cell u_cell (
            .clk (clk),
            .en  (chain_en),
            .din (din),
            .q   (cell_q[i])
        );
    end

    // Fill level and scan bookkeeping
    always_comb
    begin
        count_inc = (count_reg == CNT_W'(WINDOW)) ? count_reg : count_reg + CNT_W'(1);
        skip      = CNT_W'(WINDOW) - count_reg;
        take      = (CNT_W'(idx_reg) >= skip);
        first     = (CNT_W'(idx_reg) == skip);
        scan_last = (idx_reg == IDX_W'(WINDOW - 1));
        trimmed   = sum_reg - SUM_W'(hi_reg) - SUM_W'(lo_reg);
        divisor   = count_reg - CNT_W'(2);
        mean_zero = (quotient == '0);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (count_inc < CNT_W'(MIN_HELD)) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        s_tready  = 1'b0;
        in_scan   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_SCAN:
            begin
                in_scan = 1'b1;
            end
            ST_TRIM:
            begin
                div_start = 1'b1;
            end
            ST_DIV:
            begin
            end
            ST_DONE:
            begin
                out_load = !ovalid_reg || m_tready;
            end
            default:
            begin
            end
        endcase
    end

    assign accept   = s_tvalid && s_tready;
    assign chain_en = accept || in_scan;

    // Datapath: accumulate sum, maximum and minimum; build the result word
    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        sample_next = sample_reg;
        warm_next   = warm_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ofilt_next  = ofilt_reg;
        opass_next  = opass_reg;
        if (accept)
        begin
            count_next  = count_inc;
            sample_next = s_tdata;
            warm_next   = (count_inc < CNT_W'(MIN_HELD));
            idx_next    = '0;
            sum_next    = '0;
        end
        if (in_scan)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (take)
            begin
                sum_next = sum_reg + SUM_W'(tap);
                if (first)
                begin
                    hi_next = tap;
                    lo_next = tap;
                end
                else
                begin
                    hi_next = (tap > hi_reg) ? tap : hi_reg;
                    lo_next = (tap < lo_reg) ? tap : lo_reg;
                end
            end
        end
        if (out_load)
        begin
            ovalid_next = 1'b1;
            opass_next  = warm_reg || mean_zero;
            ofilt_next  = (warm_reg || mean_zero) ? sample_reg : quotient;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        sum_reg    <= sum_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        sample_reg <= sample_next;
        warm_reg   <= warm_next;
        ofilt_reg  <= ofilt_next;
        opass_reg  <= opass_next;
    end

    // Trimmed sum over (count - 2)
    stmf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (trimmed),
        .divisor  (divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign m_tvalid   = ovalid_reg;
    assign m_tdata    = ofilt_reg;
    assign m_tuser[0] = opass_reg;

endmodule : sliding_trimmed_mean_filter_core
`default_nettype wire
